>>> sv/ptms_pkg.sv
`timescale 1ns / 1ps

package ptms_pkg;

    // Default window storage depth
    localparam int WINDOW_DEPTH_DEF = 64;

    // Configuration register indexes
    localparam logic [1:0] REG_PH_OFFSET       = 2'd0;
    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd1;
    localparam logic [1:0] REG_WINDOW_SIZE     = 2'd2;

    // Register reset values
    localparam logic [7:0] PH_OFFSET_RST       = 8'd0;
    localparam logic [7:0] SAMPLE_INTERVAL_RST = 8'd20;
    localparam logic [6:0] WINDOW_SIZE_RST     = 7'd10;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int ELAPSED_W = 9;

    // Windows of this size and larger use the trimmed mean
    localparam int TRIM_MIN = 5;

    // pH = mean * 35 / 2048  (5.0 V / 1024 codes * 3.5 pH/V)
    localparam logic [5:0] PH_SCALE = 6'd35;
    localparam int         PH_SHIFT = 11;

endpackage

>>> sv/ptms_window.sv
`timescale 1ns / 1ps

module ptms_window import ptms_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    localparam int IDX_W = $clog2(WINDOW_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [SAMPLE_W-1:0]     rd_data_reg;
    logic                    rd_valid_reg;

    // Sample storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-entry valid bits; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/ptms_div.sv
`timescale 1ns / 1ps

module ptms_div import ptms_pkg::*; #(
    parameter int SUM_W = 17,
    parameter int D_W   = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [SUM_W-1:0] quo_reg;

    logic [D_W:0]     shifted;
    logic             ge;
    logic [D_W:0]     diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/ph_trimmed_mean_sampler.sv
// Tick without a sample: the result is loaded into the output registers when the output is free,
// else it waits in ST_PUSH; one tick per cycle while no sample is taken and the output does not stall.
// Sample tick: the window is read back one entry a cycle from the sample memory, then a
// bit-serial divider of width SUM_W = 10 + clog2(WINDOW_DEPTH+1) runs.
// One tick is in work at a time. Reset (synchronous, active low) resets the control and configuration
// registers, the counters and the per-entry valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps

module ph_trimmed_mean_sampler import ptms_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_adc_sample,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_ph_value,
    output logic [SAMPLE_W-1:0] m_window_mean,
    output logic                m_updated,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_index,
    input  logic [7:0]          cfg_wr_data
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int N_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + N_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DIVGO = 3'd2;
    localparam logic [2:0] ST_DIVW  = 3'd3;
    localparam logic [2:0] ST_PH    = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]           state_reg, state_next;

    logic [7:0]           ph_offset_reg;
    logic [7:0]           sample_interval_reg;
    logic [6:0]           window_size_reg;

    logic [IDX_W-1:0]     write_index_reg, write_index_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [7:0]           held_ph_reg, held_ph_next;
    logic [SAMPLE_W-1:0]  held_mean_reg, held_mean_next;
    logic                 pend_upd_reg, pend_upd_next;

    logic [N_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                 dat_vld_reg;
    logic [N_W-1:0]       dat_idx_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SAMPLE_W-1:0]  lo_reg, lo_next;
    logic [SAMPLE_W-1:0]  hi_reg, hi_next;

    logic                 m_valid_reg;
    logic [7:0]           m_ph_value_reg;
    logic [SAMPLE_W-1:0]  m_window_mean_reg;
    logic                 m_updated_reg;
    logic                 load_out;
    logic                 load_upd;

    logic [N_W-1:0]       n_eff;
    logic                 plain;
    logic [N_W-1:0]       divisor;
    logic                 accept;
    logic                 out_free;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 take_sample;
    logic [IDX_W-1:0]     wi_eff;
    logic [N_W-1:0]       wi_inc;

    logic                 wr_en;
    logic                 rd_en;
    logic [SAMPLE_W-1:0]  rd_data;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     quotient;
    logic [15:0]          ph_prod;
    logic [8:0]           ph_sum;

    // Effective window size, zero means one, clipped to storage depth
    always_comb begin
        if (window_size_reg == 7'd0) begin
            n_eff = N_W'(1);
        end else if (int'(window_size_reg) > WINDOW_DEPTH) begin
            n_eff = N_W'(WINDOW_DEPTH);
        end else begin
            n_eff = N_W'(window_size_reg);
        end
        plain   = int'(n_eff) < TRIM_MIN;
        divisor = plain ? n_eff : n_eff - N_W'(2);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Tick counting and ring write position
    always_comb begin
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);
        take_sample = elapsed_inc > {1'b0, sample_interval_reg};
        wi_eff      = (N_W'(write_index_reg) >= n_eff) ? '0 : write_index_reg;
        wi_inc      = N_W'(wi_eff) + N_W'(1);
    end

    assign wr_en = accept && take_sample;
    assign rd_en = (state_reg == ST_SCAN) && (rd_cnt_reg < n_eff);

    // Running sum over the read-back stream, with min/max trimming in trimmed mode
    always_comb begin
        sum_next = sum_reg;
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        if (dat_vld_reg) begin
            if (plain) begin
                sum_next = sum_reg + SUM_W'(rd_data);
            end else if (dat_idx_reg == '0) begin
                lo_next = rd_data;
            end else if (dat_idx_reg == N_W'(1)) begin
                if (lo_reg < rd_data) begin
                    hi_next = rd_data;
                end else begin
                    hi_next = lo_reg;
                    lo_next = rd_data;
                end
            end else if (rd_data < lo_reg) begin
                sum_next = sum_reg + SUM_W'(lo_reg);
                lo_next  = rd_data;
            end else if (rd_data > hi_reg) begin
                sum_next = sum_reg + SUM_W'(hi_reg);
                hi_next  = rd_data;
            end else begin
                sum_next = sum_reg + SUM_W'(rd_data);
            end
        end
    end

    // pH scaling with saturating offset
    always_comb begin
        ph_prod = 16'(held_mean_reg) * 16'(PH_SCALE);
        ph_sum  = 9'(ph_prod >> PH_SHIFT) + {1'b0, ph_offset_reg};
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        elapsed_next     = elapsed_reg;
        held_ph_next     = held_ph_reg;
        held_mean_next   = held_mean_reg;
        pend_upd_next    = pend_upd_reg;
        rd_cnt_next      = rd_en ? rd_cnt_reg + N_W'(1) : rd_cnt_reg;
        div_start        = 1'b0;
        load_out         = 1'b0;
        load_upd         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (take_sample) begin
                        elapsed_next     = '0;
                        write_index_next = (wi_inc >= n_eff) ? '0 : wi_inc[IDX_W-1:0];
                        rd_cnt_next      = '0;
                        state_next       = ST_SCAN;
                    end else begin
                        elapsed_next = elapsed_inc;
                        if (out_free) begin
                            load_out = 1'b1;
                        end else begin
                            pend_upd_next = 1'b0;
                            state_next    = ST_PUSH;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (dat_vld_reg && dat_idx_reg == n_eff - N_W'(1)) begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    held_mean_next = quotient[SAMPLE_W-1:0];
                    state_next     = ST_PH;
                end
            end
            ST_PH: begin
                held_ph_next  = ph_sum[8] ? 8'hFF : ph_sum[7:0];
                pend_upd_next = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    load_upd   = pend_upd_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a window size write restarts the ring position
        if (cfg_wr_en && cfg_wr_index == REG_WINDOW_SIZE) begin
            write_index_next = '0;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            ph_offset_reg       <= PH_OFFSET_RST;
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
            window_size_reg     <= WINDOW_SIZE_RST;
            write_index_reg     <= '0;
            elapsed_reg         <= '0;
            held_ph_reg         <= '0;
            held_mean_reg       <= '0;
            pend_upd_reg        <= 1'b0;
            rd_cnt_reg          <= '0;
            dat_vld_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            held_ph_reg   <= held_ph_next;
            held_mean_reg <= held_mean_next;
            pend_upd_reg  <= pend_upd_next;
            rd_cnt_reg    <= rd_cnt_next;
            dat_vld_reg   <= rd_en;
            write_index_reg <= write_index_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_PH_OFFSET:       ph_offset_reg       <= cfg_wr_data;
                    REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_wr_data;
                    REG_WINDOW_SIZE:     window_size_reg     <= cfg_wr_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        dat_idx_reg <= rd_cnt_reg;
        if (accept && take_sample) begin
            sum_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end else begin
            sum_reg <= sum_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
        end
        if (load_out) begin
            m_ph_value_reg    <= held_ph_reg;
            m_window_mean_reg <= held_mean_reg;
            m_updated_reg     <= load_upd;
        end
    end

    ptms_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wi_eff),
        .wr_data (s_adc_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    ptms_div #(
        .SUM_W (SUM_W),
        .D_W   (N_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_valid       = m_valid_reg;
    assign m_ph_value    = m_ph_value_reg;
    assign m_window_mean = m_window_mean_reg;
    assign m_updated     = m_updated_reg;

`ifndef SYNTHESIS
    // divider completes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIVW)
        else $error("divider done outside wait state");

    // window read-back never runs past the effective size
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> rd_cnt_reg < n_eff)
        else $error("window read beyond effective size");

    // a sampled tick starts a window scan
    a_sample_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && take_sample) |=> state_reg == ST_SCAN && rd_cnt_reg == '0)
        else $error("sample did not start a scan");

    // an output marked updated carries the result of a sampled tick
    a_upd_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && load_upd) |-> state_reg == ST_PUSH && pend_upd_reg)
        else $error("updated result without recompute");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ptms_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    // Cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT = 5000;
    // Receiver hold-off length, in cycles
    localparam int HOLD_CYCLES = 300;
    // Index with no register behind it; writes to it must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]          ph;
        logic [SAMPLE_W-1:0] mean;
        logic                upd;
    } ph_reading_t;

    typedef struct {
        bit                  is_cfg;
        logic [1:0]          idx;
        logic [7:0]          data;
        logic [SAMPLE_W-1:0] adc;
        bit                  has_exp;
        ph_reading_t         exp;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_adc_sample = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_ph_value;
    logic [SAMPLE_W-1:0] m_window_mean;
    logic                m_updated;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_wr_index = '0;
    logic [7:0]          cfg_wr_data = '0;

    ph_reading_t expected_readings[$];
    stim_row_t   stim_table[$];
    int          mismatches = 0;
    bit          steady = 1'b0;
    bit          stall_request = 1'b0;

    // Predictor state
    logic [SAMPLE_W-1:0] win_mem [DEPTH];
    int unsigned         wr_ptr = 0;
    int unsigned         tick_count = 0;
    logic [7:0]          last_ph = '0;
    logic [SAMPLE_W-1:0] last_mean = '0;
    logic [7:0]          offset_reg = PH_OFFSET_RST;
    logic [7:0]          interval_reg = SAMPLE_INTERVAL_RST;
    logic [6:0]          size_reg = WINDOW_SIZE_RST;

    ph_trimmed_mean_sampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_sample  (s_adc_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ph_value    (m_ph_value),
        .m_window_mean (m_window_mean),
        .m_updated     (m_updated),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Plain mean below TRIM_MIN entries, else drop one running min and max
    function automatic logic [SAMPLE_W-1:0] window_mean_of(input int unsigned n);
        int unsigned acc;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        acc = 0;
        if (n < TRIM_MIN) begin
            for (int unsigned i = 0; i < n; i++) acc += win_mem[i];
            return SAMPLE_W'(acc / n);
        end
        lo = (win_mem[0] < win_mem[1]) ? win_mem[0] : win_mem[1];
        hi = (win_mem[0] < win_mem[1]) ? win_mem[1] : win_mem[0];
        for (int unsigned i = 2; i < n; i++) begin
            v = win_mem[i];
            if (v < lo) begin
                acc += lo;
                lo = v;
            end else if (v > hi) begin
                acc += hi;
                hi = v;
            end else begin
                acc += v;
            end
        end
        return SAMPLE_W'(acc / (n - 2));
    endfunction

    // Advance the predictor by one tick and return the reading it shows
    function automatic ph_reading_t predict_tick(input logic [SAMPLE_W-1:0] adc);
        ph_reading_t r;
        int unsigned n;
        int unsigned ph;
        if (tick_count < 511) tick_count++;
        r.upd = 1'b0;
        if (tick_count > interval_reg) begin
            // zero size acts as one entry, oversize clamps to the depth
            n = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
            if (wr_ptr >= n) wr_ptr = 0;
            win_mem[wr_ptr] = adc;
            wr_ptr++;
            if (wr_ptr >= n) wr_ptr = 0;
            last_mean = window_mean_of(n);
            ph = ((int'(last_mean) * int'(PH_SCALE)) >> PH_SHIFT) + int'(offset_reg);
            last_ph = (ph > 255) ? 8'd255 : ph[7:0];
            tick_count = 0;
            r.upd = 1'b1;
        end
        r.ph = last_ph;
        r.mean = last_mean;
        return r;
    endfunction

    // Drop valid and wait until every expected reading has arrived
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PH_OFFSET:       offset_reg = data;
            REG_SAMPLE_INTERVAL: interval_reg = data;
            REG_WINDOW_SIZE: begin
                size_reg = data[6:0];
                wr_ptr = 0;
            end
            default: ;
        endcase
    endtask

    // Offer one tick, hold it until the transfer, then queue its reading
    task automatic send_tick(input logic [SAMPLE_W-1:0] adc, input bit has_exp,
                             input ph_reading_t typed);
        ph_reading_t pred;
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_adc_sample <= adc;
        do @(posedge aclk); while (!s_ready);
        pred = predict_tick(adc);
        expected_readings.push_back(has_exp ? typed : pred);
    endtask

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [7:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic [SAMPLE_W-1:0] adc, input bit has_exp,
                                           input ph_reading_t exp);
        stim_row_t r;
        r = '{default: '0};
        r.adc = adc;
        r.has_exp = has_exp;
        r.exp = exp;
        return r;
    endfunction

    // Result checker
    always @(posedge aclk) begin
        ph_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                flag_error($sformatf("result with nothing expected: ph %0d mean %0d upd %0d",
                                     m_ph_value, m_window_mean, m_updated));
            end else begin
                want = expected_readings.pop_front();
                if (m_ph_value !== want.ph)
                    flag_error($sformatf("ph_value got %0d expected %0d",
                                         m_ph_value, want.ph));
                if (m_window_mean !== want.mean)
                    flag_error($sformatf("window_mean got %0d expected %0d",
                                         m_window_mean, want.mean));
                if (m_updated !== want.upd)
                    flag_error($sformatf("updated got %0d expected %0d",
                                         m_updated, want.upd));
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 14);
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        ph_reading_t none;
        logic [SAMPLE_W-1:0] adc;
        logic [7:0] offset_val;
        logic [7:0] interval_val;
        logic [7:0] size_val;
        int n_items;
        none = '0;
        adc = '0;
        foreach (win_mem[k]) win_mem[k] = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset defaults, extremes, clamped sizes, plain and trimmed mean
        stim_table.push_back(tick_row(10'd0, 1, '{8'd0, 10'd0, 1'b0}));
        stim_table.push_back(tick_row(10'd1023, 1, '{8'd0, 10'd0, 1'b0}));
        stim_table.push_back(cfg_row(REG_SAMPLE_INTERVAL, 8'd0));
        stim_table.push_back(cfg_row(REG_WINDOW_SIZE, 8'd1));
        stim_table.push_back(tick_row(10'd1023, 1, '{8'd17, 10'd1023, 1'b1}));
        stim_table.push_back(tick_row(10'd0, 1, '{8'd0, 10'd0, 1'b1}));
        stim_table.push_back(cfg_row(REG_PH_OFFSET, 8'd255));
        stim_table.push_back(tick_row(10'd1023, 1, '{8'd255, 10'd1023, 1'b1}));
        stim_table.push_back(tick_row(10'd0, 1, '{8'd255, 10'd0, 1'b1}));
        stim_table.push_back(cfg_row(REG_PH_OFFSET, 8'h5A));
        stim_table.push_back(cfg_row(REG_UNUSED, 8'hFF));
        stim_table.push_back(cfg_row(REG_WINDOW_SIZE, 8'd0));
        stim_table.push_back(tick_row(10'd512, 0, none));
        stim_table.push_back(cfg_row(REG_WINDOW_SIZE, 8'd4));
        stim_table.push_back(tick_row(10'd1023, 0, none));
        stim_table.push_back(tick_row(10'd1, 0, none));
        stim_table.push_back(tick_row(10'd700, 0, none));
        stim_table.push_back(tick_row(10'd3, 0, none));
        stim_table.push_back(cfg_row(REG_WINDOW_SIZE, 8'd5));
        stim_table.push_back(tick_row(10'd1023, 0, none));
        stim_table.push_back(tick_row(10'd0, 0, none));
        stim_table.push_back(tick_row(10'd1023, 0, none));
        stim_table.push_back(tick_row(10'd0, 0, none));
        stim_table.push_back(tick_row(10'd512, 0, none));
        // 0xFF masks to 127, which clamps to the full depth
        stim_table.push_back(cfg_row(REG_WINDOW_SIZE, 8'hFF));
        stim_table.push_back(tick_row(10'd1023, 0, none));
        stim_table.push_back(tick_row(10'd1023, 0, none));
        stim_table.push_back(tick_row(10'd0, 0, none));
        stim_table.push_back(tick_row(10'd600, 0, none));
        // Sample every other tick: held values in between
        stim_table.push_back(cfg_row(REG_SAMPLE_INTERVAL, 8'd1));
        stim_table.push_back(tick_row(10'd100, 0, none));
        stim_table.push_back(tick_row(10'd200, 0, none));
        stim_table.push_back(tick_row(10'd300, 0, none));

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                wait_idle();
                write_cfg(stim_table[k].idx, stim_table[k].data);
            end else begin
                send_tick(stim_table[k].adc, stim_table[k].has_exp, stim_table[k].exp);
            end
        end

        // Random phases, each with its own register setting
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(3))
                0: offset_val = 8'd0;
                1: offset_val = 8'd255;
                default: offset_val = 8'($urandom_range(255));
            endcase
            if (phase == 7) begin
                interval_val = 8'd255;
            end else begin
                case ($urandom_range(9))
                    6: interval_val = 8'd1;
                    7: interval_val = 8'd2;
                    8: interval_val = 8'($urandom_range(3, 12));
                    9: interval_val = 8'($urandom_range(13, 40));
                    default: interval_val = 8'd0;
                endcase
            end
            case ($urandom_range(7))
                0: size_val = 8'd0;
                1: size_val = 8'd1;
                2: size_val = 8'd4;
                3: size_val = 8'd5;
                4: size_val = 8'd64;
                5: size_val = 8'($urandom_range(65, 127));
                default: size_val = 8'($urandom_range(2, 64));
            endcase
            // upper data bit is outside the size register and must be dropped
            if ($urandom_range(3) == 0) size_val[7] = 1'b1;

            wait_idle();
            write_cfg(REG_PH_OFFSET, offset_val);
            write_cfg(REG_SAMPLE_INTERVAL, interval_val);
            write_cfg(REG_WINDOW_SIZE, size_val);

            steady = (phase == 9);
            n_items = (phase == 7) ? 260 : 60;
            for (int i = 0; i < n_items; i++) begin
                if (phase == 3 && i == 10) stall_request = 1'b1;
                if (phase == 5 && i == 30) wait_idle();
                // bias toward extremes and repeats to hit the min/max trimming ties
                case ($urandom_range(9))
                    0: adc = '0;
                    1: adc = '1;
                    2: ;
                    default: adc = SAMPLE_W'($urandom_range(1023));
                endcase
                send_tick(adc, 0, none);
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (100) @(posedge aclk);
        if (expected_readings.size() != 0)
            flag_error($sformatf("%0d expected readings never arrived",
                                 expected_readings.size()));
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
